// ===== rtl/gsig_pkg.sv =====
// ----------------------------------------------------------------------------
// gsig_pkg
// Shared types and constants of the grid strip index generator.
// ----------------------------------------------------------------------------
package gsig_pkg;

  localparam int MAX_COLUMNS = 1024;
  localparam int MAX_ROWS    = 1024;

  localparam int SIZE_W  = 11;
  localparam int ROW_W   = 10;
  localparam int COL_W   = 10;
  localparam int INDEX_W = 20;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_SECOND,
    PH_REPEAT_A,
    PH_REPEAT_B
  } phase_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] maxv);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end
    return r;
  endfunction

endpackage

// ===== rtl/grid_strip_index_generator_top.sv =====
// ----------------------------------------------------------------------------
// grid_strip_index_generator_top
// Serpentine triangle-strip index stream for a row-major vertex grid.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall, payload restart): each beat asks for
//   one index; restart = 1 rewinds to the first index of the strip and emits it.
//   Output channel (out_valid / out_stall): one beat per input beat carrying
//   vertex_index, last_of_mesh and exhausted. After the final index every
//   beat reports exhausted with index 0 until a restart.
//   The output beat is registered and appears in the cycle after its input
//   beat; throughput is one beat per cycle unless stalled. The sequence state
//   and output register update in a single combinational step on acceptance.
//   When the receiver stalls, the result holds in the output register and
//   in_stall rises only while that register is full and stalled.
//   Config writes (cfg_we, cfg_index, cfg_data) set grid_columns or
//   grid_rows, clamped to 1 .. 1024, and rewind the sequence.
//   Reset (rst, synchronous) sets a 2 x 2 grid, rewinds the sequence and
//   empties the output register.
// ----------------------------------------------------------------------------
module grid_strip_index_generator_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [gsig_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gsig_pkg::SIZE_W-1:0]         cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                restart,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [gsig_pkg::INDEX_W-1:0]        vertex_index,
  output logic                                last_of_mesh,
  output logic                                exhausted
);

  logic [gsig_pkg::SIZE_W-1:0]  cols;
  logic [gsig_pkg::SIZE_W-1:0]  rows;
  logic [gsig_pkg::ROW_W-1:0]   band_row;
  logic [gsig_pkg::COL_W-1:0]   column_pos;
  logic [gsig_pkg::INDEX_W-1:0] band_base;
  gsig_pkg::phase_t             emit_phase;
  logic                         finished;

  logic [gsig_pkg::ROW_W-1:0]   band_row_next;
  logic [gsig_pkg::COL_W-1:0]   column_pos_next;
  logic [gsig_pkg::INDEX_W-1:0] band_base_next;
  gsig_pkg::phase_t             emit_phase_next;
  logic                         finished_next;

  logic [gsig_pkg::ROW_W-1:0]   cur_row;
  logic [gsig_pkg::COL_W-1:0]   cur_col_pos;
  logic [gsig_pkg::INDEX_W-1:0] cur_base;
  gsig_pkg::phase_t             cur_phase;
  logic                         cur_finished;

  logic                         accept;
  logic                         empty_now;
  logic                         odd;
  logic [gsig_pkg::SIZE_W-1:0]  col;
  logic [gsig_pkg::INDEX_W-1:0] lo_idx;
  logic [gsig_pkg::INDEX_W-1:0] hi_idx;
  logic [gsig_pkg::INDEX_W-1:0] rep_idx;
  logic [gsig_pkg::INDEX_W-1:0] idx;
  logic                         last;

  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    cur_row      = restart ? '0 : band_row;
    cur_col_pos  = restart ? '0 : column_pos;
    cur_base     = restart ? '0 : band_base;
    cur_phase    = restart ? gsig_pkg::PH_FIRST : emit_phase;
    cur_finished = restart ? 1'b0 : finished;

    empty_now = cur_finished || (rows < gsig_pkg::SIZE_W'(2)) ||
                ({1'b0, cur_row} >= rows - gsig_pkg::SIZE_W'(1));

    odd = cur_row[0];
    col = odd ? (cols - gsig_pkg::SIZE_W'(1) - {1'b0, cur_col_pos}) : {1'b0, cur_col_pos};
    lo_idx  = cur_base + gsig_pkg::INDEX_W'(col);
    hi_idx  = cur_base + gsig_pkg::INDEX_W'(cols) + gsig_pkg::INDEX_W'(col);
    rep_idx = odd ? (cur_base + gsig_pkg::INDEX_W'(cols))
                  : (cur_base + (gsig_pkg::INDEX_W'(cols) << 1)
                     - gsig_pkg::INDEX_W'(1));

    band_row_next   = cur_row;
    column_pos_next = cur_col_pos;
    band_base_next  = cur_base;
    emit_phase_next = cur_phase;
    finished_next   = cur_finished;
    idx  = '0;
    last = 1'b0;

    if (empty_now) begin
      finished_next = 1'b1;
    end else begin
      unique case (cur_phase)
        gsig_pkg::PH_FIRST: begin
          idx = odd ? hi_idx : lo_idx;
          emit_phase_next = gsig_pkg::PH_SECOND;
        end
        gsig_pkg::PH_SECOND: begin
          idx = odd ? lo_idx : hi_idx;
          if (({1'b0, cur_col_pos} + gsig_pkg::SIZE_W'(1)) >= cols) begin
            emit_phase_next = gsig_pkg::PH_REPEAT_A;
          end else begin
            column_pos_next = cur_col_pos + gsig_pkg::COL_W'(1);
            emit_phase_next = gsig_pkg::PH_FIRST;
          end
        end
        gsig_pkg::PH_REPEAT_A: begin
          idx = rep_idx;
          emit_phase_next = gsig_pkg::PH_REPEAT_B;
        end
        default: begin
          idx  = rep_idx;
          last = ({1'b0, cur_row} == rows - gsig_pkg::SIZE_W'(2));
          band_row_next   = cur_row + gsig_pkg::ROW_W'(1);
          band_base_next  = cur_base + gsig_pkg::INDEX_W'(cols);
          column_pos_next = '0;
          emit_phase_next = gsig_pkg::PH_FIRST;
          if (last) begin
            finished_next = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cols       <= gsig_pkg::SIZE_W'(2);
      rows       <= gsig_pkg::SIZE_W'(2);
      band_row   <= '0;
      column_pos <= '0;
      band_base  <= '0;
      emit_phase <= gsig_pkg::PH_FIRST;
      finished   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          gsig_pkg::REG_GRID_COLUMNS: begin
            cols <= gsig_pkg::clamp_size(cfg_data, gsig_pkg::SIZE_W'(gsig_pkg::MAX_COLUMNS));
          end
          gsig_pkg::REG_GRID_ROWS: begin
            rows <= gsig_pkg::clamp_size(cfg_data, gsig_pkg::SIZE_W'(gsig_pkg::MAX_ROWS));
          end
          default: begin
          end
        endcase
      end
      if (cfg_we && (cfg_index == gsig_pkg::REG_GRID_COLUMNS ||
                     cfg_index == gsig_pkg::REG_GRID_ROWS)) begin
        band_row   <= '0;
        column_pos <= '0;
        band_base  <= '0;
        emit_phase <= gsig_pkg::PH_FIRST;
        finished   <= 1'b0;
      end else if (accept) begin
        band_row   <= band_row_next;
        column_pos <= column_pos_next;
        band_base  <= band_base_next;
        emit_phase <= emit_phase_next;
        finished   <= finished_next;
      end
      if (accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      vertex_index <= idx;
      last_of_mesh <= last;
      exhausted    <= empty_now;
    end
  end

endmodule

// ===== rtl/gsig_checker.sv =====
// ----------------------------------------------------------------------------
// gsig_checker
// Port-level checks of the grid strip index generator.
// ----------------------------------------------------------------------------
module gsig_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [gsig_pkg::INDEX_W-1:0]  vertex_index,
  input logic                          last_of_mesh,
  input logic                          exhausted
);

  a_exhausted_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && exhausted |-> vertex_index == '0 && !last_of_mesh)
    else $error("exhausted beat carries index or last flag");

  a_beat_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted beat produced no result");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output register free");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(vertex_index) &&
                               $stable(last_of_mesh) && $stable(exhausted))
    else $error("stalled result changed");

endmodule

bind grid_strip_index_generator_top gsig_checker u_gsig_checker (.*);

// ===== tb/grid_strip_index_generator_top_tb.sv =====
// ----------------------------------------------------------------------------
// grid_strip_index_generator_top_tb
// Self-checking bench for the serpentine triangle-strip index generator.
// A clocked driver sends restart beats from a pending queue, and a clocked
// monitor checks every output beat against a cycle-free model of the strip
// walk. Grid sizes are reprogrammed between phases, only while the block is
// idle. Both sides idle and stall at random. The stimulus covers the clamped
// extremes, single-row and empty grids, exhaustion, restarts and writes to
// unmapped register indexes.
// ----------------------------------------------------------------------------
module grid_strip_index_generator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [gsig_pkg::CFG_IDX_W-1:0] REG_UNUSED_A = gsig_pkg::CFG_IDX_W'(2);
  localparam logic [gsig_pkg::CFG_IDX_W-1:0] REG_UNUSED_B = gsig_pkg::CFG_IDX_W'(3);
  localparam int WATCHDOG_LIMIT = 500;
  localparam int RANDOM_ITEMS   = 1400;
  localparam int PHASE_CAP      = 300;

  typedef struct packed {
    logic [gsig_pkg::INDEX_W-1:0] index;
    logic                         is_last;
    logic                         is_exhausted;
  } strip_beat_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_we = 1'b0;
  logic [gsig_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [gsig_pkg::SIZE_W-1:0]    cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic                           restart = 1'b0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [gsig_pkg::INDEX_W-1:0]   vertex_index;
  logic                           last_of_mesh;
  logic                           exhausted;

  grid_strip_index_generator_top DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .restart      (restart),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .vertex_index (vertex_index),
    .last_of_mesh (last_of_mesh),
    .exhausted    (exhausted)
  );

  always #1 clk = ~clk;

  // strip model state
  logic [gsig_pkg::SIZE_W-1:0]  grid_cols_q;
  logic [gsig_pkg::SIZE_W-1:0]  grid_rows_q;
  logic [gsig_pkg::ROW_W-1:0]   band_row;
  logic [gsig_pkg::COL_W-1:0]   column_pos;
  logic [gsig_pkg::INDEX_W-1:0] band_base;
  gsig_pkg::phase_t             emit_phase;
  logic                         strip_done;

  logic        restart_pending[$];
  strip_beat_t strip_expect[$];
  int          error_count = 0;
  int          send_gap = 0;
  int          recv_wait = 0;
  int          recv_next;
  int          quiet_cycles = 0;
  logic        send_calm = 1'b0;
  logic        recv_calm = 1'b0;

  function automatic int fit_size(input logic [gsig_pkg::SIZE_W-1:0] v, input int top);
    if (v == '0) return 1;
    if (int'(v) > top) return top;
    return int'(v);
  endfunction

  function automatic int strip_length(input logic [gsig_pkg::SIZE_W-1:0] c,
                                      input logic [gsig_pkg::SIZE_W-1:0] r);
    int rows;
    rows = fit_size(r, gsig_pkg::MAX_ROWS);
    return (rows < 2) ? 0 : (rows - 1) * (2 * fit_size(c, gsig_pkg::MAX_COLUMNS) + 2);
  endfunction

  task automatic rewind_strip();
    band_row   = '0;
    column_pos = '0;
    band_base  = '0;
    emit_phase = gsig_pkg::PH_FIRST;
    strip_done = 1'b0;
  endtask

  task automatic advance_strip(input logic rs);
    strip_beat_t b;
    int cols, rows, col, base, idx;
    logic odd;
    cols = fit_size(grid_cols_q, gsig_pkg::MAX_COLUMNS);
    rows = fit_size(grid_rows_q, gsig_pkg::MAX_ROWS);
    b = '0;
    idx = 0;
    if (rs) rewind_strip();
    if (strip_done || rows < 2 || int'(band_row) >= rows - 1) begin
      strip_done = 1'b1;
      b.is_exhausted = 1'b1;
    end else begin
      odd  = band_row[0];
      base = int'(band_base);
      col  = odd ? cols - 1 - int'(column_pos) : int'(column_pos);
      case (emit_phase)
        gsig_pkg::PH_FIRST: begin
          idx = odd ? base + cols + col : base + col;
          emit_phase = gsig_pkg::PH_SECOND;
        end
        gsig_pkg::PH_SECOND: begin
          idx = odd ? base + col : base + cols + col;
          if (int'(column_pos) + 1 >= cols) begin
            emit_phase = gsig_pkg::PH_REPEAT_A;
          end else begin
            column_pos = column_pos + gsig_pkg::COL_W'(1);
            emit_phase = gsig_pkg::PH_FIRST;
          end
        end
        gsig_pkg::PH_REPEAT_A: begin
          idx = odd ? base + cols : base + 2 * cols - 1;
          emit_phase = gsig_pkg::PH_REPEAT_B;
        end
        default: begin
          idx = odd ? base + cols : base + 2 * cols - 1;
          b.is_last  = (int'(band_row) == rows - 2);
          band_row   = band_row + gsig_pkg::ROW_W'(1);
          band_base  = band_base + gsig_pkg::INDEX_W'(cols);
          column_pos = '0;
          emit_phase = gsig_pkg::PH_FIRST;
          if (b.is_last) strip_done = 1'b1;
        end
      endcase
      b.index = gsig_pkg::INDEX_W'(idx);
    end
    strip_expect = {strip_expect, b};
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      restart  <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall) advance_strip(restart);
      if (in_valid && in_stall) begin
        in_valid <= 1'b1;
      end else if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (restart_pending.size() != 0) begin
        in_valid <= 1'b1;
        restart  <= restart_pending.pop_front();
        send_gap <= send_calm ? 0 : $urandom_range(0, 6);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output monitor
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      recv_wait <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (strip_expect.size() == 0) begin
          report_mismatch("beat with nothing expected", int'(vertex_index), 0);
        end else begin
          strip_beat_t want;
          want = strip_expect.pop_front();
          if (vertex_index !== want.index)
            report_mismatch("vertex_index", int'(vertex_index), int'(want.index));
          if (last_of_mesh !== want.is_last)
            report_mismatch("last_of_mesh", int'(last_of_mesh), int'(want.is_last));
          if (exhausted !== want.is_exhausted)
            report_mismatch("exhausted", int'(exhausted), int'(want.is_exhausted));
        end
        recv_next = recv_calm ? 0 : $urandom_range(0, 6);
      end else begin
        recv_next = (recv_wait != 0) ? recv_wait - 1 : 0;
      end
      recv_wait <= recv_next;
      out_stall <= (recv_next != 0);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic wait_drain();
    while (restart_pending.size() != 0 || in_valid || strip_expect.size() != 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic program_reg(input logic [gsig_pkg::CFG_IDX_W-1:0] idx,
                             input logic [gsig_pkg::SIZE_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == gsig_pkg::REG_GRID_COLUMNS) begin
      grid_cols_q = val;
      rewind_strip();
    end else if (idx == gsig_pkg::REG_GRID_ROWS) begin
      grid_rows_q = val;
      rewind_strip();
    end
  endtask

  task automatic queue_strip(input int n, input int noise_pct, input logic lead);
    for (int i = 0; i < n; i++) begin
      logic rs;
      rs = (i == 0) ? lead : ($urandom_range(0, 99) < noise_pct);
      restart_pending = {restart_pending, rs};
    end
  endtask

  function automatic logic [gsig_pkg::SIZE_W-1:0] pick_cols();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return gsig_pkg::SIZE_W'($urandom_range(1, 6));
    if (r < 90) return gsig_pkg::SIZE_W'($urandom_range(7, 40));
    case ($urandom_range(0, 3))
      0: return '0;
      1: return gsig_pkg::SIZE_W'(gsig_pkg::MAX_COLUMNS);
      2: return '1;
      default: return gsig_pkg::SIZE_W'($urandom_range(0, 2047));
    endcase
  endfunction

  function automatic logic [gsig_pkg::SIZE_W-1:0] pick_rows();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return gsig_pkg::SIZE_W'($urandom_range(2, 6));
    if (r < 88) return gsig_pkg::SIZE_W'($urandom_range(0, 1));
    if (r < 96) return gsig_pkg::SIZE_W'($urandom_range(7, 12));
    return ($urandom_range(0, 1) != 0) ? gsig_pkg::SIZE_W'(gsig_pkg::MAX_ROWS) : '1;
  endfunction

  initial begin
    int sent, n;
    logic [gsig_pkg::SIZE_W-1:0] c, r;
    grid_cols_q = gsig_pkg::SIZE_W'(2);
    grid_rows_q = gsig_pkg::SIZE_W'(2);
    rewind_strip();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset grid: full strip, exhaustion, restart
    queue_strip(8, 0, 1'b0);
    queue_strip(2, 0, 1'b1);
    wait_drain();
    // unmapped indexes must not rewind
    program_reg(REG_UNUSED_A, '1);
    program_reg(REG_UNUSED_B, gsig_pkg::SIZE_W'(1));
    queue_strip(3, 0, 1'b0);
    wait_drain();

    program_reg(gsig_pkg::REG_GRID_COLUMNS, '0);
    program_reg(gsig_pkg::REG_GRID_ROWS, gsig_pkg::SIZE_W'(3));
    queue_strip(9, 0, 1'b0);
    wait_drain();
    program_reg(gsig_pkg::REG_GRID_ROWS, gsig_pkg::SIZE_W'(1));
    queue_strip(2, 0, 1'b1);
    wait_drain();
    program_reg(gsig_pkg::REG_GRID_COLUMNS, '1);
    program_reg(gsig_pkg::REG_GRID_ROWS, '0);
    queue_strip(1, 0, 1'b0);
    wait_drain();

    // clamped maximum grid, partial walks
    program_reg(gsig_pkg::REG_GRID_ROWS, '1);
    queue_strip(150, 1, 1'b0);
    wait_drain();
    program_reg(gsig_pkg::REG_GRID_COLUMNS, gsig_pkg::SIZE_W'(1));
    program_reg(gsig_pkg::REG_GRID_ROWS, gsig_pkg::SIZE_W'(gsig_pkg::MAX_ROWS));
    queue_strip(120, 1, 1'b1);
    wait_drain();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      send_calm <= ($urandom_range(0, 3) == 0);
      recv_calm <= ($urandom_range(0, 3) == 0);
      c = pick_cols();
      r = pick_rows();
      if ($urandom_range(0, 1) != 0) begin
        program_reg(gsig_pkg::REG_GRID_COLUMNS, c);
        program_reg(gsig_pkg::REG_GRID_ROWS, r);
      end else begin
        program_reg(gsig_pkg::REG_GRID_ROWS, r);
        if ($urandom_range(0, 3) != 0) program_reg(gsig_pkg::REG_GRID_COLUMNS, c);
      end
      if ($urandom_range(0, 9) == 0)
        program_reg(($urandom_range(0, 1) != 0) ? REG_UNUSED_A : REG_UNUSED_B,
                    gsig_pkg::SIZE_W'($urandom_range(0, 2047)));
      n = strip_length(grid_cols_q, grid_rows_q) + $urandom_range(1, 4);
      if (n > PHASE_CAP) n = PHASE_CAP;
      queue_strip(n, ($urandom_range(0, 4) == 0) ? 30 : 2, 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 4) == 0) begin
        wait_drain();
        queue_strip(n, 2, 1'($urandom_range(0, 1)));
        n = 2 * n;
      end
      sent += n;
      wait_drain();
    end

    send_calm <= 1'b0;
    recv_calm <= 1'b0;
    wait_drain();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
